FILE: src/sme_pkg.sv
// Shared constants, types and the rank lookup of the stable matching enumerator.
package sme_pkg;

	localparam int PEOPLE      = 3;
	localparam int MAX_RESULTS = 10;
	localparam int IDX_W       = (PEOPLE > 2) ? $clog2(PEOPLE) : 1;
	localparam int WIFE_W      = 2;
	localparam int PATH_W      = WIFE_W * PEOPLE;
	localparam int TABLE_W     = 18;
	localparam int OUT_W       = 6;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int POS_W       = 5;

	// One result beat handed from the sequencer to the output register.
	typedef struct packed {
		logic              valid;
		logic [PATH_W-1:0] wife;
		logic              last;
	} sme_emit_t;

	// Two-bit rank of b in row a; positions past the table read as zero.
	function automatic logic [1:0] rank_of(input logic [TABLE_W-1:0] tbl,
		input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
		logic [POS_W-1:0]   pos;
		logic [TABLE_W-1:0] sh;
		pos = POS_W'(2 * (int'(a) * PEOPLE + int'(b)));
		sh  = tbl >> pos;
		return sh[1:0];
	endfunction

endpackage

FILE: src/sme_pair_unit.sv
// Shared compare unit: tests one earlier man against the man being placed.
module sme_pair_unit
	import sme_pkg::*;
(
	input  logic [TABLE_W-1:0] man_tbl,
	input  logic [TABLE_W-1:0] woman_tbl,
	input  logic [IDX_W-1:0]   early_man,
	input  logic [IDX_W-1:0]   col_man,
	input  logic [IDX_W-1:0]   col_wife,
	input  logic [IDX_W-1:0]   early_wife,
	output logic               conflict
);

	logic same_wife;
	logic block_a;
	logic block_b;

	always_comb begin
		same_wife = (col_wife == early_wife);
		// early man prefers the new wife, and she prefers him to her new husband
		block_a = (rank_of(man_tbl, early_man, col_wife) < rank_of(man_tbl, early_man, early_wife))
			&& (rank_of(woman_tbl, col_wife, early_man) < rank_of(woman_tbl, col_wife, col_man));
		// new man prefers the earlier wife, and she prefers him to her husband
		block_b = (rank_of(man_tbl, col_man, early_wife) < rank_of(man_tbl, col_man, col_wife))
			&& (rank_of(woman_tbl, early_wife, col_man) < rank_of(woman_tbl, early_wife, early_man));
		conflict = same_wife | block_a | block_b;
	end

endmodule

FILE: src/sme_seq.sv
// Backtracking sequencer: walks the search tree, one pair check per cycle.
module sme_seq
	import sme_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [TABLE_W-1:0] man_rank_table,
	input  logic [TABLE_W-1:0] woman_rank_table,
	input  logic               slot_free,
	output sme_emit_t          emit
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ADV   = 6'b000010,
		S_CHK   = 6'b000100,
		S_LOAD  = 6'b001000,
		S_FOUND = 6'b010000,
		S_FIN   = 6'b100000
	} sme_state_t;

	sme_state_t         state_q;
	logic [TABLE_W-1:0] man_tbl_q;
	logic [TABLE_W-1:0] woman_tbl_q;
	logic [PATH_W-1:0]  path_q;
	logic [PATH_W-1:0]  held_q;
	logic               held_valid_q;
	logic [IDX_W-1:0]   cm_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WIFE_W-1:0]  cur_q;
	logic               ret_q;
	logic [CNT_W-1:0]   count_q;

	logic [WIFE_W:0]    next_wife;
	logic [PATH_W-1:0]  path_sh;
	logic [WIFE_W-1:0]  idx_wife;
	logic               conflict;
	logic               final_slot;

	always_comb begin
		next_wife  = ret_q ? ({1'b0, cur_q} + (WIFE_W+1)'(1)) : '0;
		path_sh    = path_q >> (WIFE_W * int'(idx_q));
		idx_wife   = path_sh[WIFE_W-1:0];
		final_slot = (count_q == CNT_W'(MAX_RESULTS - 1));
	end

	sme_pair_unit u_pair (
		.man_tbl    (man_tbl_q),
		.woman_tbl  (woman_tbl_q),
		.early_man  (idx_q),
		.col_man    (cm_q),
		.col_wife   (IDX_W'(cur_q)),
		.early_wife (IDX_W'(idx_wife)),
		.conflict   (conflict)
	);

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		emit.valid = held_valid_q && slot_free && ((state_q == S_FOUND) || (state_q == S_FIN));
		emit.wife  = held_q;
		emit.last  = (state_q == S_FIN) || final_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			man_tbl_q    <= '0;
			woman_tbl_q  <= '0;
			path_q       <= '1;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			cm_q         <= '0;
			idx_q        <= '0;
			cur_q        <= '0;
			ret_q        <= 1'b0;
			count_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						man_tbl_q    <= man_rank_table;
						woman_tbl_q  <= woman_rank_table;
						cm_q         <= '0;
						ret_q        <= 1'b0;
						held_valid_q <= 1'b0;
						count_q      <= '0;
						state_q      <= S_ADV;
					end
				end
				S_ADV: begin
					if (next_wife >= (WIFE_W+1)'(PEOPLE)) begin
						// out of wives for this man: step back, or finish when he is man 0
						if (cm_q == '0) begin
							state_q <= S_FIN;
						end else begin
							cm_q    <= cm_q - IDX_W'(1);
							idx_q   <= cm_q - IDX_W'(1);
							state_q <= S_LOAD;
						end
					end else begin
						cur_q <= next_wife[WIFE_W-1:0];
						for (int m = 0; m < PEOPLE; m++) begin
							if (cm_q == IDX_W'(m))
								path_q[WIFE_W*m +: WIFE_W] <= next_wife[WIFE_W-1:0];
						end
						idx_q   <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (idx_q == cm_q) begin
						if (cm_q == IDX_W'(PEOPLE - 1)) begin
							state_q <= S_FOUND;
						end else begin
							cm_q    <= cm_q + IDX_W'(1);
							ret_q   <= 1'b0;
							state_q <= S_ADV;
						end
					end else if (conflict) begin
						ret_q   <= 1'b1;
						state_q <= S_ADV;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_LOAD: begin
					cur_q   <= idx_wife;
					ret_q   <= 1'b1;
					state_q <= S_ADV;
				end
				S_FOUND: begin
					if (!held_valid_q || slot_free) begin
						if (held_valid_q && final_slot) begin
							held_valid_q <= 1'b0;
							state_q      <= S_IDLE;
						end else begin
							if (held_valid_q)
								count_q <= count_q + CNT_W'(1);
							held_q       <= path_q;
							held_valid_q <= 1'b1;
							ret_q        <= 1'b1;
							state_q      <= S_ADV;
						end
					end
				end
				S_FIN: begin
					if (!held_valid_q || slot_free) begin
						held_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/stable_matching_enumerator_core.sv
// Top level of the stable matching enumerator: sequencer plus output register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  in      | in_valid  | in_stall  | man_rank_table, woman_rank_table
//  out     | out_valid | out_stall | wife_per_man, last_matching
//
// One instance is worked on at a time; in_stall stays high from the accepted
// beat until the last matching has been handed to the output register.
// Each tried wife is placed in S_ADV, then checked in S_CHK against each earlier
// man in turn in the shared pair unit, with one more S_CHK pass when she passes
// every check; each step back goes through S_ADV and S_LOAD, and each matching
// found goes through S_FOUND.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A stalled output holds the sequencer at the next result until the slot frees.
module stable_matching_enumerator_core
	import sme_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [TABLE_W-1:0] man_rank_table,
	input  logic [TABLE_W-1:0] woman_rank_table,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OUT_W-1:0]   wife_per_man,
	output logic               last_matching
);

	sme_emit_t             emit;
	logic                  slot_free;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      wife_q;
	logic                  last_q;
	logic [PATH_W+OUT_W-1:0] wife_ext;

	// the output slot takes a new beat when empty or being drained this cycle
	assign slot_free = !out_valid_q || !out_stall;

	sme_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.man_rank_table   (man_rank_table),
		.woman_rank_table (woman_rank_table),
		.slot_free        (slot_free),
		.emit             (emit)
	);

	// fit the packed wives to the output width: pad or drop high fields
	assign wife_ext = {{OUT_W{1'b0}}, emit.wife};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until the beat is taken
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			wife_q <= wife_ext[OUT_W-1:0];
			last_q <= emit.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign wife_per_man  = wife_q;
	assign last_matching = last_q;

endmodule

FILE: sim/stable_matching_enumerator_core_tb.sv
// Self-checking testbench for the stable matching enumerator core.
`timescale 1ns / 1ps

module stable_matching_enumerator_core_tb;
	import sme_pkg::*;

	// How the expected matchings of a stimulus row are obtained.
	typedef enum logic [1:0] {
		KNOWN_NONE,              // work it out with the predictor
		KNOWN_EVERY_PERMUTATION, // all ranks tie, so every matching is stable
		KNOWN_FIRST_CHOICE       // everyone is the first choice of their own pick
	} known_t;

	typedef struct packed {
		logic [TABLE_W-1:0] men;
		logic [TABLE_W-1:0] women;
		known_t             known;
	} stim_row_t;

	// One stable matching as it leaves the block.
	typedef struct packed {
		logic [OUT_W-1:0] wife;
		logic             last;
	} matching_t;

	localparam int DIRECTED_COUNT = 15;
	localparam int RANDOM_COUNT   = 395;
	localparam int DRAIN_CYCLES   = 200;  // watch time for stray beats after the drain
	localparam int HOLD_OFF_BEATS = 400;  // long receiver hold-off
	localparam int HOLD_OFF_ITEM  = 150;  // random item that triggers it

	// With every rank tied, all six matchings come out in lexicographic order.
	localparam logic [OUT_W-1:0] EVERY_PERMUTATION [6] = '{
		6'h24, 6'h18, 6'h21, 6'h09, 6'h12, 6'h06
	};

	// Rank tables written as hex: 0x094A4 gives man or woman k first choice k,
	// 0x24924 gives every row the order 0,1,2, 0x06186 the order 2,1,0.
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{18'h00000, 18'h00000, KNOWN_EVERY_PERMUTATION},
		'{18'h3FFFF, 18'h3FFFF, KNOWN_EVERY_PERMUTATION},
		'{18'h00000, 18'h3FFFF, KNOWN_EVERY_PERMUTATION},
		'{18'h3FFFF, 18'h00000, KNOWN_EVERY_PERMUTATION},
		'{18'h094A4, 18'h094A4, KNOWN_FIRST_CHOICE},
		'{18'h094A4, 18'h00000, KNOWN_NONE},
		'{18'h24924, 18'h24924, KNOWN_NONE},
		'{18'h24924, 18'h06186, KNOWN_NONE},
		'{18'h15555, 18'h2AAAA, KNOWN_NONE},
		'{18'h00001, 18'h20000, KNOWN_NONE},
		'{18'h20000, 18'h00001, KNOWN_NONE},
		'{18'h2AAAA, 18'h15555, KNOWN_NONE},
		'{18'h094A4, 18'h24924, KNOWN_NONE},
		'{18'h06186, 18'h094A4, KNOWN_NONE},
		'{18'h3FFFE, 18'h1FFFF, KNOWN_NONE}
	};

	logic               clk;
	logic               arst_n           = 1'b0;
	logic               in_valid         = 1'b0;
	logic               in_stall;
	logic [TABLE_W-1:0] man_rank_table   = '0;
	logic [TABLE_W-1:0] woman_rank_table = '0;
	logic               out_valid;
	logic               out_stall        = 1'b0;
	logic [OUT_W-1:0]   wife_per_man;
	logic               last_matching;

	// Matchings still owed by the block, oldest first.
	matching_t pending_matchings[$];
	matching_t oldest_matching;

	int  mismatches       = 0;
	int  instances_sent   = 0;
	int  matchings_seen   = 0;
	int  instance_ends    = 0;
	int  beats_taken      = 0;
	bit  sender_quiet     = 1'b0;
	bit  hold_off_wanted  = 1'b0;
	bit  hold_off_done    = 1'b0;

	stable_matching_enumerator_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.man_rank_table   (man_rank_table),
		.woman_rank_table (woman_rank_table),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.wife_per_man     (wife_per_man),
		.last_matching    (last_matching)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Read the two-bit rank in row 'row', column 'col'; bits past the table read zero.
	function automatic logic [1:0] rank_in_table(input logic [TABLE_W-1:0] tbl,
		input int row, input int col);
		int         pos;
		logic [1:0] rank;
		pos     = 2 * (row * PEOPLE + col);
		rank[0] = (pos < TABLE_W) ? tbl[pos] : 1'b0;
		rank[1] = (pos + 1 < TABLE_W) ? tbl[pos + 1] : 1'b0;
		return rank;
	endfunction

	// Walk every assignment of wives in lexicographic order (man 0 most
	// significant) and queue each one that is a permutation with no blocking
	// pair. Ties never block since both sides must strictly prefer each other.
	function automatic void predict_stable_matchings(input logic [TABLE_W-1:0] men,
		input logic [TABLE_W-1:0] women);
		int               wife [PEOPLE];
		int               code, rest, m, i, v, w, total;
		bit               stable;
		logic [OUT_W-1:0] packed_wives;
		matching_t        found[$];
		matching_t        one;
		total = PEOPLE ** PEOPLE;
		for (code = 0; code < total; code++) begin
			rest = code;
			for (m = PEOPLE - 1; m >= 0; m--) begin
				wife[m] = rest % PEOPLE;
				rest    = rest / PEOPLE;
			end
			stable = 1'b1;
			for (m = 1; m < PEOPLE; m++) begin
				for (i = 0; i < m; i++) begin
					v = wife[i];
					w = wife[m];
					if (v == w)
						stable = 1'b0;
					// man i and the wife of man m
					if (rank_in_table(men, i, w) < rank_in_table(men, i, v) &&
						rank_in_table(women, w, i) < rank_in_table(women, w, m))
						stable = 1'b0;
					// man m and the wife of man i
					if (rank_in_table(men, m, v) < rank_in_table(men, m, w) &&
						rank_in_table(women, v, m) < rank_in_table(women, v, i))
						stable = 1'b0;
				end
			end
			if (stable && found.size() < MAX_RESULTS) begin
				packed_wives = '0;
				for (m = 0; m < PEOPLE; m++)
					packed_wives[2 * m +: 2] = 2'(wife[m]);
				one.wife = packed_wives;
				one.last = 1'b0;
				found.push_back(one);
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[k])
			pending_matchings.push_back(found[k]);
	endfunction

	// Build a rank table row by row: each row is a shuffled order of ranks,
	// and with the given odds a row is flattened to one tied rank instead.
	function automatic logic [TABLE_W-1:0] random_rank_table(input int tie_percent);
		logic [TABLE_W-1:0] tbl;
		int                 order [PEOPLE];
		int                 r, j, pick, swap, pos, tied;
		tbl = '0;
		for (r = 0; r < PEOPLE; r++) begin
			for (j = 0; j < PEOPLE; j++)
				order[j] = j;
			for (j = PEOPLE - 1; j > 0; j--) begin
				pick        = $urandom_range(0, j);
				swap        = order[j];
				order[j]    = order[pick];
				order[pick] = swap;
			end
			if ($urandom_range(0, 99) < tie_percent) begin
				tied = $urandom_range(0, 3);
				for (j = 0; j < PEOPLE; j++)
					order[j] = tied;
			end
			for (j = 0; j < PEOPLE; j++) begin
				pos = 2 * (r * PEOPLE + j);
				if (pos + 1 < TABLE_W)
					tbl[pos +: 2] = 2'(order[j]);
			end
		end
		return tbl;
	endfunction

	// Offer one problem instance; entered and left at a falling edge. The
	// expected matchings are queued at the edge that accepts the beat.
	task automatic offer_instance(input logic [TABLE_W-1:0] men,
		input logic [TABLE_W-1:0] women, input known_t known);
		int        gap;
		matching_t one;
		gap = sender_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid         <= 1'b1;
		man_rank_table   <= men;
		woman_rank_table <= women;
		do
			@(posedge clk);
		while (in_stall);
		case (known)
			KNOWN_EVERY_PERMUTATION: begin
				foreach (EVERY_PERMUTATION[k]) begin
					one.wife = EVERY_PERMUTATION[k];
					one.last = (k == 5);
					pending_matchings.push_back(one);
				end
			end
			KNOWN_FIRST_CHOICE: begin
				one.wife = 6'h24;
				one.last = 1'b1;
				pending_matchings.push_back(one);
			end
			default: begin
				predict_stable_matchings(men, women);
			end
		endcase
		instances_sent++;
		@(negedge clk);
	endtask

	// Compare every accepted result beat against the oldest owed matching.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_matchings.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat wife_per_man=%h last_matching=%b, none expected",
					$time, wife_per_man, last_matching);
			end else begin
				oldest_matching = pending_matchings.pop_front();
				matchings_seen++;
				if (oldest_matching.last)
					instance_ends++;
				if (wife_per_man !== oldest_matching.wife) begin
					mismatches++;
					$display("%0t: wife_per_man expected %h actual %h",
						$time, oldest_matching.wife, wife_per_man);
				end
				if (last_matching !== oldest_matching.last) begin
					mismatches++;
					$display("%0t: last_matching expected %b actual %b",
						$time, oldest_matching.last, last_matching);
				end
			end
		end
	end

	// Receiver: hold off a random number of cycles per beat, with quiet
	// stretches, and once for a long stretch so the block backs up and
	// stalls its input while the sender keeps offering.
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_wanted && !hold_off_done) begin
				hold          = HOLD_OFF_BEATS;
				hold_off_done = 1'b1;
			end else if ((beats_taken / 30) % 3 == 2) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 15);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			beats_taken++;
			@(negedge clk);
		end
	end

	// Sender: reset, the directed rows, then random instances, then drain.
	initial begin
		int        idx;
		int        pick;
		logic [TABLE_W-1:0] men;
		logic [TABLE_W-1:0] women;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (idx = 0; idx < DIRECTED_COUNT; idx++)
			offer_instance(DIRECTED_ROWS[idx].men, DIRECTED_ROWS[idx].women,
				DIRECTED_ROWS[idx].known);

		// Mostly strict preference lists with random content, some with tied
		// rows, and the rest raw bits so that rank 3 and every bit toggle.
		for (idx = 0; idx < RANDOM_COUNT; idx++) begin
			sender_quiet = ((idx / 40) % 3 == 1);
			if (idx == HOLD_OFF_ITEM)
				hold_off_wanted = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				men   = random_rank_table(0);
				women = random_rank_table(0);
			end else if (pick < 75) begin
				men   = random_rank_table(50);
				women = random_rank_table(50);
			end else begin
				men   = TABLE_W'($urandom_range(0, (1 << TABLE_W) - 1));
				women = TABLE_W'($urandom_range(0, (1 << TABLE_W) - 1));
			end
			offer_instance(men, women, KNOWN_NONE);
		end
		in_valid <= 1'b0;

		// Drain the owed matchings, then watch a while for stray beats.
		while (pending_matchings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d problem instances (%0d directed), checked %0d stable matchings",
			instances_sent, DIRECTED_COUNT, matchings_seen);
		$display("ending %0d instances, with one long output hold-off; %0d mismatches.",
			instance_ends, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: a correct run ends far sooner than this.
	initial begin
		#6_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
src/sme_pkg.sv
src/sme_pair_unit.sv
src/sme_seq.sv
src/stable_matching_enumerator_core.sv
sim/stable_matching_enumerator_core_tb.sv
